FILE: sv/dst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dst_pkg
// Shared constants and types of the disjoint sparse table range-fold engine.
// ----------------------------------------------------------------------------
package dst_pkg;
  localparam int MaxElements = 1024;
  localparam int Levels      = 10;
  localparam int DataWidth   = 32;
  localparam int IdxW  = $clog2(MaxElements);
  localparam int CntW  = $clog2(MaxElements + 1);
  localparam int LvlW  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int AddrW = LvlW + IdxW;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [LvlW-1:0]      lvl_t;
  typedef logic [AddrW-1:0]     addr_t;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeBuild = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpMin = 2'd1;
  localparam logic [1:0] OpMax = 2'd2;
  localparam logic [1:0] OpXor = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadRange = 2'd1;
  localparam logic [1:0] StNotBuilt = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  function automatic data_t combine(input logic [1:0] op, input data_t a, input data_t b);
    data_t r;
    case (op)
      OpAdd:   r = a + b;
      OpMin:   r = (a < b) ? a : b;
      OpMax:   r = (a > b) ? a : b;
      OpXor:   r = a ^ b;
      default: r = a ^ b;
    endcase
    return r;
  endfunction

  function automatic addr_t mk_addr(input lvl_t l, input idx_t i);
    return {l, i};
  endfunction
endpackage
`default_nettype wire

FILE: sv/dst_table_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dst_table_mem
// Level table storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dst_table_mem (
  input  wire logic             clk,
  input  wire dst_pkg::mem_req_t req,
  output dst_pkg::data_t        rdata_a,
  output dst_pkg::data_t        rdata_b
);
  import dst_pkg::*;

  localparam int Depth = 1 << AddrW;
  data_t mem [Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end
endmodule
`default_nettype wire

FILE: sv/dst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dst_ctrl
// Sequencer for load, build, query and clear items.
// ----------------------------------------------------------------------------
module dst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_mode,
  input  wire dst_pkg::data_t    in_elem,
  input  wire dst_pkg::idx_t     in_left,
  input  wire dst_pkg::cnt_t     in_right,
  input  wire logic [1:0]        op_sel,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output dst_pkg::data_t         out_fold,
  output logic [1:0]             out_status,
  output dst_pkg::mem_req_t      req,
  input  wire dst_pkg::data_t    rdata_a,
  input  wire dst_pkg::data_t    rdata_b
);
  import dst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_QRD, S_BLVL, S_BRD, S_BWR, S_OUT
  } state_t;

  state_t state_r;
  cnt_t   count_r;
  logic   built_r;
  lvl_t   lvl_r;
  cnt_t   j_r;      // start of current 2*width block
  cnt_t   k_r;      // position inside the current half
  logic   side_r;   // 0 suffix half, 1 prefix half
  cnt_t   h_r, t_r;
  data_t  acc_r;
  logic   first_r;
  data_t  fold_r;
  logic [1:0] st_r;
  logic   comb_r;   // query result combines two entries

  cnt_t width;
  cnt_t hh, tt;
  idx_t last_q;
  idx_t x_q;
  lvl_t qlvl;
  logic qlvl_ok;

  always_comb begin
    width  = cnt_t'(1) << lvl_r;
    hh     = ((j_r + width) < count_r) ? cnt_t'(j_r + width) : count_r;
    tt     = ((hh + width) < count_r) ? cnt_t'(hh + width) : count_r;
    last_q = idx_t'(in_right - cnt_t'(1));
    x_q    = in_left ^ last_q;
    qlvl   = '0;
    qlvl_ok = 1'b1;
    for (int b = 1; b < IdxW; b++) begin
      if (x_q[b]) begin
        if (b < Levels) qlvl = lvl_t'(b);
        else qlvl_ok = 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_fold   = fold_r;
  assign out_status = st_r;

  // Memory requests depend on state; the build reads base[k] and writes row[k].
  always_comb begin
    req = '0;
    case (state_r)
      S_IDLE: begin
        req.raddr_a = mk_addr(qlvl, in_left);
        req.raddr_b = mk_addr(qlvl, last_q);
        if (in_tvalid && in_mode == ModeLoad && count_r < cnt_t'(MaxElements)) begin
          req.we    = 1'b1;
          req.waddr = mk_addr('0, idx_t'(count_r));
          req.wdata = in_elem;
        end
      end
      S_BRD: req.raddr_a = mk_addr('0, idx_t'(k_r));
      S_BWR: begin
        req.we    = 1'b1;
        req.waddr = mk_addr(lvl_r, idx_t'(k_r));
        req.wdata = first_r ? rdata_a :
                    (side_r ? combine(op_sel, acc_r, rdata_a)
                            : combine(op_sel, rdata_a, acc_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      built_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          case (in_mode)
            ModeLoad: begin
              fold_r <= '0;
              if (count_r < cnt_t'(MaxElements)) begin
                count_r <= count_r + cnt_t'(1);
                built_r <= 1'b0;
                st_r    <= StOk;
              end else st_r <= StOverflow;
              state_r <= S_OUT;
            end
            ModeClear: begin
              count_r <= '0;
              built_r <= 1'b0;
            end
            ModeBuild: begin
              lvl_r   <= lvl_t'(1);
              j_r     <= '0;
              state_r <= (Levels > 1) ? S_BLVL : S_IDLE;
              if (Levels == 1) built_r <= 1'b1;
            end
            ModeQuery: begin
              fold_r <= '0;
              comb_r <= (in_left != last_q);
              if (!built_r) begin
                st_r <= StNotBuilt; state_r <= S_OUT;
              end else if ({1'b0, in_left} >= in_right || in_right > count_r ||
                           !qlvl_ok) begin
                st_r <= StBadRange; state_r <= S_OUT;
              end else begin
                st_r <= StOk; state_r <= S_QRD;
              end
            end
            default: ;
          endcase
        end
        S_QRD: begin
          fold_r  <= comb_r ? combine(op_sel, rdata_a, rdata_b) : rdata_a;
          state_r <= S_OUT;
        end
        S_BLVL: begin
          // Start the suffix half at j_r, else next level or finish the build.
          if (j_r >= count_r) begin
            if (32'(lvl_r) == Levels - 1) begin
              built_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              lvl_r <= lvl_r + lvl_t'(1);
              j_r   <= '0;
            end
          end else begin
            h_r <= hh; t_r <= tt;
            side_r <= 1'b0; first_r <= 1'b1;
            k_r <= hh - cnt_t'(1);
            state_r <= S_BRD;
          end
        end
        S_BRD: state_r <= S_BWR;
        S_BWR: begin
          acc_r   <= req.wdata;
          first_r <= 1'b0;
          state_r <= S_BRD;
          if (!side_r) begin
            if (k_r == j_r) begin
              if (h_r == count_r) begin
                j_r <= count_r; state_r <= S_BLVL;
              end else begin
                side_r <= 1'b1; first_r <= 1'b1; k_r <= h_r;
              end
            end else k_r <= k_r - cnt_t'(1);
          end else begin
            if (k_r + cnt_t'(1) >= t_r) begin
              j_r <= t_r; state_r <= S_BLVL;
            end else k_r <= k_r + cnt_t'(1);
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/disjoint_sparse_table_range_fold_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disjoint_sparse_table_range_fold_top
// Range-fold engine over a disjoint sparse table held in one memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tdata: mode, element_value, left_index, right_end
// out_     master     tdata: fold_value, status
// cfg_     slave      op_select
// A query makes one registered read of both entries, then the combine; one
// that reports an error skips the read. A build reads each base element and
// writes its level entry in turn, block by block, through the single
// read-modify-write of the level table. One item is in flight at a time; a
// waiting result holds the input stalled. rst_n is synchronous; the table
// itself is not cleared.
module disjoint_sparse_table_range_fold_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] mode, [33:2] element_value, [43:34] left_index, [54:44] right_end
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] fold_value, [33:32] status
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);
  import dst_pkg::*;

  logic [1:0] op_r;
  mem_req_t   req;
  data_t      rdata_a, rdata_b, fold;
  logic [1:0] status;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) op_r <= OpAdd;
    else if (cfg_valid) op_r <= cfg_data;
  end

  dst_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_mode(in_tdata[1:0]), .in_elem(in_tdata[33:2]),
    .in_left(in_tdata[43:34]), .in_right(in_tdata[54:44]),
    .op_sel(op_r), .out_tvalid, .out_tready,
    .out_fold(fold), .out_status(status),
    .req, .rdata_a, .rdata_b
  );

  dst_table_mem u_mem (.clk, .req, .rdata_a, .rdata_b);

  assign out_tdata = {6'd0, status, fold};
endmodule
`default_nettype wire
